### hw/rtl/dfs_pkg.sv
// Shared types and constants for the delimited field selector.
// Holds the channel payload structs, register indexes and the front-to-back command.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dfs_pkg;

  localparam int CFG_W     = 34;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_RANGE_A = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MODE    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SPLIT   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_JOIN    = 3'd6;

  localparam int MODE_FIELD = 0;
  localparam int MODE_COMPL = 1;
  localparam int MODE_ONLY  = 2;
  localparam int MODE_NUL   = 3;

  localparam logic [7:0] TERM_NL     = 8'h0A;
  localparam logic [7:0] TERM_NUL    = 8'h00;
  localparam logic [7:0] SPLIT_RESET = 8'h09;
  localparam logic [8:0] JOIN_RESET  = 9'h109;

  // held-field count width, covers the whole hold depth range
  localparam int HCNT_W = 6;
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;

  typedef struct packed {
    logic       operation;
    logic [7:0] data_byte;
  } dfs_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_end;
    logic       hold_overflow;
  } dfs_out_t;

  // one command per item that produces output: held bytes first, then at most one byte
  typedef struct packed {
    logic              has_held;
    logic [HCNT_W-1:0] held_cnt;
    logic              has_byte;
    logic [7:0]        emit_byte;
    logic              ovf;
  } dfs_cmd_t;

  typedef struct packed {
    logic              en;
    logic [HCNT_W-1:0] addr;
    logic [7:0]        data;
  } dfs_hwr_t;

  function automatic logic range_hit(input logic [CFG_W-1:0] r, input logic [15:0] p);
    return r[33] && (p >= r[15:0]) && (r[32] || (p <= r[31:16]));
  endfunction

endpackage

`default_nettype wire

### hw/rtl/dfs_queue.sv
// Short command queue between the front and back parts of the selector.
// Depends on dfs_pkg for the command type and depth.
`timescale 1ns / 1ps
`default_nettype none

module dfs_queue (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  dfs_pkg::dfs_cmd_t     push_cmd,
  output logic                  full,
  input  wire logic             pop,
  output dfs_pkg::dfs_cmd_t     head,
  output logic                  empty
);
  import dfs_pkg::*;

  dfs_cmd_t            slot_r [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]     cnt_r, cnt_nxt;

  assign full  = (cnt_r == (QPTR_W+1)'(QDEPTH));
  assign empty = (cnt_r == '0);
  assign head  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/dfs_front.sv
// Front part: configuration registers, item acceptance, record/field tracking.
// Classifies each item into at most one output command. Depends on dfs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dfs_front #(
  parameter int HOLD_DEPTH  = 56,
  parameter int RANGE_COUNT = 4
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  dfs_pkg::dfs_in_t                     in_data,
  input  wire logic                            cfg_we,
  input  wire logic [dfs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [dfs_pkg::CFG_W-1:0]       cfg_wdata,
  output logic                                 q_push,
  output dfs_pkg::dfs_cmd_t                    q_cmd,
  input  wire logic                            q_full,
  output dfs_pkg::dfs_hwr_t                    hold_wr,
  input  wire logic                            held_done
);
  import dfs_pkg::*;

  localparam int HC_W = $clog2(HOLD_DEPTH + 1);

  logic [CFG_W-1:0] range_r [RANGE_COUNT];
  logic [3:0]       mode_r;
  logic [7:0]       split_r;
  logic [8:0]       join_r;

  logic [HC_W-1:0]  hcnt_r, hcnt_nxt;
  logic [15:0]      pos_r, pos_nxt;
  logic             delim_r, delim_nxt;
  logic             any_r, any_nxt;
  logic             open_r, open_nxt;
  logic             ovf_r, ovf_nxt;
  logic             busy_r, busy_nxt;

  logic             acc;
  logic             finish;
  logic             hwr_en;
  logic [7:0]       term;
  logic [15:0]      pos_inc;
  logic [15:0]      eval_pt;
  logic             sel_eval;
  logic             sel0;
  logic             is_split;
  logic             field;

  function automatic logic sel_at(input logic [15:0] p);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < RANGE_COUNT; i++) begin
      hit = hit | range_hit(range_r[i], p);
    end
    return hit ^ mode_r[MODE_COMPL];
  endfunction

  assign in_stall = busy_r || q_full;
  assign acc      = in_valid && !in_stall;
  assign term     = mode_r[MODE_NUL] ? TERM_NUL : TERM_NL;
  assign field    = mode_r[MODE_FIELD];
  assign is_split = (in_data.data_byte == split_r);
  assign pos_inc  = (pos_r == 16'hFFFF) ? pos_r : pos_r + 16'd1;

  // pick the one position this item may test besides field zero
  always_comb begin
    if (field && !delim_r) begin
      eval_pt = 16'd1;
    end else if (field && is_split) begin
      eval_pt = pos_inc;
    end else begin
      eval_pt = pos_r;
    end
  end

  // range registers and mode are read inside sel_at, so evaluate here
  always_comb begin
    sel_eval = sel_at(eval_pt);
    sel0     = sel_at(16'd0);
  end

  always_comb begin
    hcnt_nxt  = hcnt_r;
    pos_nxt   = pos_r;
    delim_nxt = delim_r;
    any_nxt   = any_r;
    open_nxt  = open_r;
    ovf_nxt   = ovf_r;
    finish    = 1'b0;
    hwr_en    = 1'b0;
    q_cmd     = '0;
    q_cmd.ovf = ovf_r;

    if (in_data.operation) begin
      finish = open_r;
    end else if (in_data.data_byte == term) begin
      finish = 1'b1;
    end else begin
      open_nxt = 1'b1;
      if (!field) begin
        if (sel_eval) begin
          q_cmd.has_byte  = 1'b1;
          q_cmd.emit_byte = in_data.data_byte;
        end
        pos_nxt = pos_inc;
      end else if (!delim_r) begin
        if (is_split) begin
          delim_nxt = 1'b1;
          pos_nxt   = 16'd1;
          if (sel0) begin
            q_cmd.has_held = (hcnt_r != '0);
            any_nxt        = 1'b1;
          end
          if (sel_eval) begin
            if ((sel0 || any_r) && join_r[8]) begin
              q_cmd.has_byte  = 1'b1;
              q_cmd.emit_byte = join_r[7:0];
            end
            any_nxt = 1'b1;
          end
        end else if (hcnt_r < HC_W'(HOLD_DEPTH)) begin
          hwr_en   = 1'b1;
          hcnt_nxt = hcnt_r + 1'b1;
        end else begin
          ovf_nxt = 1'b1;
        end
      end else if (is_split) begin
        pos_nxt = pos_inc;
        if (sel_eval) begin
          if (any_r && join_r[8]) begin
            q_cmd.has_byte  = 1'b1;
            q_cmd.emit_byte = join_r[7:0];
          end
          any_nxt = 1'b1;
        end
      end else if (sel_eval) begin
        q_cmd.has_byte  = 1'b1;
        q_cmd.emit_byte = in_data.data_byte;
      end
    end

    if (finish) begin
      if (!field || delim_r) begin
        q_cmd.has_byte  = 1'b1;
        q_cmd.emit_byte = term;
      end else if (!mode_r[MODE_ONLY]) begin
        q_cmd.has_held  = (hcnt_r != '0);
        q_cmd.has_byte  = 1'b1;
        q_cmd.emit_byte = term;
      end
      hcnt_nxt  = '0;
      pos_nxt   = '0;
      delim_nxt = 1'b0;
      any_nxt   = 1'b0;
      open_nxt  = 1'b0;
      ovf_nxt   = 1'b0;
    end

    q_cmd.held_cnt = HCNT_W'(hcnt_r);
  end

  assign q_push       = acc && (q_cmd.has_held || q_cmd.has_byte);
  assign hold_wr.en   = acc && hwr_en;
  assign hold_wr.addr = HCNT_W'(hcnt_r);
  assign hold_wr.data = in_data.data_byte;

  // hold off every item while the back still reads the hold store
  always_comb begin
    busy_nxt = busy_r;
    if (q_push && q_cmd.has_held) begin
      busy_nxt = 1'b1;
    end else if (held_done) begin
      busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hcnt_r  <= '0;
      pos_r   <= '0;
      delim_r <= 1'b0;
      any_r   <= 1'b0;
      open_r  <= 1'b0;
      ovf_r   <= 1'b0;
      busy_r  <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      if (acc) begin
        hcnt_r  <= hcnt_nxt;
        pos_r   <= pos_nxt;
        delim_r <= delim_nxt;
        any_r   <= any_nxt;
        open_r  <= open_nxt;
        ovf_r   <= ovf_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < RANGE_COUNT; i++) begin
        range_r[i] <= '0;
      end
      mode_r  <= '0;
      split_r <= SPLIT_RESET;
      join_r  <= JOIN_RESET;
    end else if (cfg_we) begin
      for (int i = 0; i < RANGE_COUNT; i++) begin
        if (cfg_index == REG_RANGE_A + CFG_IDX_W'(i)) begin
          range_r[i] <= cfg_wdata;
        end
      end
      if (cfg_index == REG_MODE) begin
        mode_r <= cfg_wdata[3:0];
      end
      if (cfg_index == REG_SPLIT) begin
        split_r <= cfg_wdata[7:0];
      end
      if (cfg_index == REG_JOIN) begin
        join_r <= cfg_wdata[8:0];
      end
    end
  end

endmodule

`default_nettype wire

### hw/rtl/dfs_back.sv
// Back part: hold store memory, command execution and the output register.
// Drains held first-field bytes, then the command's single byte. Depends on dfs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dfs_back #(
  parameter int HOLD_DEPTH = 56
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          q_empty,
  input  dfs_pkg::dfs_cmd_t  q_head,
  output logic               q_pop,
  input  dfs_pkg::dfs_hwr_t  hold_wr,
  output logic               held_done,
  output logic               out_valid,
  input  wire logic          out_stall,
  output dfs_pkg::dfs_out_t  out_data
);
  import dfs_pkg::*;

  localparam int HA_W = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_HELD = 2'd1;
  localparam logic [1:0] ST_BYTE = 2'd2;

  logic [7:0]        mem [HOLD_DEPTH];
  logic [7:0]        rd_data_r;
  logic              rd_en;
  logic [HA_W-1:0]   rd_addr;

  logic [1:0]        state_r, state_nxt;
  logic [HCNT_W-1:0] idx_r, idx_nxt, idx_inc;
  logic [HCNT_W-1:0] cnt_r;
  logic              has_byte_r;
  logic [7:0]        byte_r;
  logic              ovf_r;
  logic              latch;

  logic              can_load;
  logic              load;
  dfs_out_t          load_data;
  logic              last;
  logic              out_valid_r;
  dfs_out_t          out_data_r;

  assign can_load  = !out_valid_r || !out_stall;
  assign idx_inc   = idx_r + 1'b1;
  assign last      = (idx_inc == cnt_r);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    q_pop     = 1'b0;
    latch     = 1'b0;
    rd_en     = 1'b0;
    rd_addr   = idx_r[HA_W-1:0];
    load      = 1'b0;
    load_data = '0;
    held_done = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          if (q_head.has_held) begin
            q_pop     = 1'b1;
            latch     = 1'b1;
            rd_en     = 1'b1;
            rd_addr   = '0;
            idx_nxt   = '0;
            state_nxt = ST_HELD;
          end else if (can_load) begin
            q_pop     = 1'b1;
            load      = 1'b1;
            load_data = '{out_byte: q_head.emit_byte, run_end: 1'b1,
                          hold_overflow: q_head.ovf};
          end
        end
      end
      ST_HELD: begin
        if (can_load) begin
          load      = 1'b1;
          load_data = '{out_byte: rd_data_r, run_end: last && !has_byte_r,
                        hold_overflow: ovf_r};
          if (last) begin
            held_done = 1'b1;
            state_nxt = has_byte_r ? ST_BYTE : ST_IDLE;
          end else begin
            // fetch the next held byte while this one goes out
            rd_en   = 1'b1;
            rd_addr = idx_inc[HA_W-1:0];
            idx_nxt = idx_inc;
          end
        end
      end
      ST_BYTE: begin
        if (can_load) begin
          load      = 1'b1;
          load_data = '{out_byte: byte_r, run_end: 1'b1, hold_overflow: ovf_r};
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (hold_wr.en) begin
      mem[hold_wr.addr[HA_W-1:0]] <= hold_wr.data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (can_load) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (latch) begin
      cnt_r      <= q_head.held_cnt;
      has_byte_r <= q_head.has_byte;
      byte_r     <= q_head.emit_byte;
      ovf_r      <= q_head.ovf;
    end
    if (load) begin
      out_data_r <= load_data;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/delimited_field_selector_core.sv
// Delimited field selector: byte/field selection over a record stream.
// A selected byte passes through the command queue and the output register to out_*.
// Throughput: one item per cycle unless stalled; draining the held first field
// stalls input until every held byte is read through the hold store's single port.
// Reset: synchronous, active low; clears record state and loads register defaults.
`timescale 1ns / 1ps
`default_nettype none

module delimited_field_selector_core #(
  parameter int HOLD_DEPTH  = 56,
  parameter int RANGE_COUNT = 4
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  dfs_pkg::dfs_in_t                     in_data,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output dfs_pkg::dfs_out_t                    out_data,
  input  wire logic                            cfg_we,
  input  wire logic [dfs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [dfs_pkg::CFG_W-1:0]       cfg_wdata
);
  import dfs_pkg::*;

  logic      q_push;
  dfs_cmd_t  q_cmd;
  logic      q_full;
  logic      q_pop;
  dfs_cmd_t  q_head;
  logic      q_empty;
  dfs_hwr_t  hold_wr;
  logic      held_done;

  dfs_front #(
    .HOLD_DEPTH  (HOLD_DEPTH),
    .RANGE_COUNT (RANGE_COUNT)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .q_push    (q_push),
    .q_cmd     (q_cmd),
    .q_full    (q_full),
    .hold_wr   (hold_wr),
    .held_done (held_done)
  );

  dfs_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty)
  );

  dfs_back #(
    .HOLD_DEPTH (HOLD_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .hold_wr   (hold_wr),
    .held_done (held_done),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

### hw/rtl/dfs_checker.sv
// Port-level checks for the delimited field selector, bound to the top level.
// Depends on dfs_pkg and delimited_field_selector_core.
`timescale 1ns / 1ps
`default_nettype none

module dfs_checker (
  input wire logic         clk,
  input wire logic         rst_n,
  input wire logic         in_stall,
  input wire logic         out_valid,
  input wire logic         out_stall,
  input dfs_pkg::dfs_out_t out_data
);
  import dfs_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // results of one item leave back to back once the previous one is taken
  a_run_cont: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_data.run_end |=> out_valid)
    else $error("gap inside a run of results");

  a_rst_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_rst_in: assert property (@(posedge clk)
    !rst_n |=> !in_stall)
    else $error("input stalled after reset");

endmodule

bind delimited_field_selector_core dfs_checker u_dfs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire

### tb/delimited_field_selector_core_test.sv
// Self-checking bench for delimited_field_selector_core: directed rows, long-record
// cases, then randomized records checked against an in-bench selection predictor.
// Depends on dfs_pkg and the core RTL.
`timescale 1ns / 1ps

module delimited_field_selector_core_test;
  import dfs_pkg::*;

  localparam int HOLD_DEPTH      = 56;
  localparam int SETTLE_CYCLES   = HOLD_DEPTH + 24;
  localparam int LONG_HOLD_CYC   = 300;
  localparam int RAND_PHASES     = 7;
  localparam int ITEMS_PER_PHASE = 18;
  localparam int OVF_LEN         = HOLD_DEPTH + 4;
  localparam int unsigned CYCLE_LIMIT = 1_500_000;

  localparam logic OP_DATA = 1'b0;
  localparam logic OP_END  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_RANGE_B = REG_RANGE_A + 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_C = REG_RANGE_A + 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_D = REG_RANGE_A + 3'd3;

  localparam int RNG_OPEN = 32;
  localparam int RNG_EN   = 33;

  localparam logic [7:0] CH_TAB = 8'h09;

  typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_t;

  typedef struct {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_W-1:0]      val;
    dfs_in_t               item;
    bit                    typed;
    logic [7:0]            want;
  } plan_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  dfs_in_t               in_data;
  logic                  out_valid;
  logic                  out_stall;
  dfs_out_t              out_data;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_W-1:0]      cfg_wdata;

  // predictor copy of registers and record state
  logic [CFG_W-1:0]  sel_range [4];
  logic [3:0]        mode_r;
  logic [7:0]        split_r;
  logic [8:0]        out_delim_r;
  logic [7:0]        held_bytes [HOLD_DEPTH];
  int                held_n;
  logic [15:0]       field_pos;
  bit                delim_seen;
  bit                any_sel;
  bit                rec_open;
  bit                held_lost;

  dfs_out_t   step_res [$];
  dfs_out_t   expected_bytes_q [$];
  plan_row_t  plan_q [$];

  int          err_cnt = 0;
  int unsigned cycle_cnt = 0;
  bit          in_idle_on;
  bit          out_idle_on;
  bit          long_hold;

  delimited_field_selector_core #(
    .HOLD_DEPTH  (HOLD_DEPTH),
    .RANGE_COUNT (4)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // ---------------- selection predictor ----------------

  function automatic logic [CFG_W-1:0] mk_range(input bit en, input bit open_end,
                                                input logic [15:0] lo, input logic [15:0] hi);
    return {en, open_end, hi, lo};
  endfunction

  function automatic bit pos_hit(input logic [15:0] p);
    bit hit;
    hit = 1'b0;
    for (int k = 0; k < 4; k++) begin
      if (sel_range[k][RNG_EN] && p >= sel_range[k][15:0] &&
          (sel_range[k][RNG_OPEN] || p <= sel_range[k][31:16]))
        hit = 1'b1;
    end
    return hit ^ mode_r[MODE_COMPL];
  endfunction

  task automatic clear_record();
    held_n     = 0;
    field_pos  = '0;
    delim_seen = 1'b0;
    any_sel    = 1'b0;
    rec_open   = 1'b0;
    held_lost  = 1'b0;
  endtask

  task automatic put_byte(input logic [7:0] b);
    dfs_out_t r;
    r.out_byte      = b;
    r.run_end       = 1'b0;
    r.hold_overflow = held_lost;
    step_res.insert(step_res.size(), r);
  endtask

  task automatic put_held();
    for (int i = 0; i < held_n; i++) put_byte(held_bytes[i]);
  endtask

  task automatic open_field();
    if (pos_hit(field_pos)) begin
      if (any_sel && out_delim_r[8]) put_byte(out_delim_r[7:0]);
      any_sel = 1'b1;
    end
  endtask

  task automatic close_record(input logic [7:0] term);
    if (!mode_r[MODE_FIELD] || delim_seen) begin
      put_byte(term);
    end else if (!mode_r[MODE_ONLY]) begin
      put_held();
      put_byte(term);
    end
    clear_record();
  endtask

  task automatic predict_item(input dfs_in_t it);
    logic [7:0] term;
    logic [7:0] b;
    dfs_out_t   last;
    step_res.delete();
    term = mode_r[MODE_NUL] ? TERM_NUL : TERM_NL;
    b = it.data_byte;
    if (it.operation == OP_END) begin
      if (rec_open) close_record(term);
    end else if (b == term) begin
      close_record(term);
    end else begin
      rec_open = 1'b1;
      if (!mode_r[MODE_FIELD]) begin
        if (pos_hit(field_pos)) put_byte(b);
        if (field_pos != 16'hFFFF) field_pos = field_pos + 16'd1;
      end else if (!delim_seen) begin
        if (b == split_r) begin
          delim_seen = 1'b1;
          if (pos_hit(16'd0)) begin
            put_held();
            any_sel = 1'b1;
          end
          field_pos = 16'd1;
          open_field();
        end else if (held_n < HOLD_DEPTH) begin
          held_bytes[held_n] = b;
          held_n++;
        end else begin
          held_lost = 1'b1;
        end
      end else if (b == split_r) begin
        if (field_pos != 16'hFFFF) field_pos = field_pos + 16'd1;
        open_field();
      end else if (pos_hit(field_pos)) begin
        put_byte(b);
      end
    end
    // mark the last result of this item
    if (step_res.size() > 0) begin
      last = step_res.pop_back();
      last.run_end = 1'b1;
      step_res.insert(step_res.size(), last);
    end
  endtask

  // ---------------- drivers ----------------

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_MODE:  mode_r      = val[3:0];
      REG_SPLIT: split_r     = val[7:0];
      REG_JOIN:  out_delim_r = val[8:0];
      default:   sel_range[idx[1:0]] = val;
    endcase
  endtask

  task automatic send_item(input dfs_in_t it, input bit typed, input logic [7:0] want);
    int       gap;
    dfs_out_t r;
    gap = in_idle_on ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!(in_valid && !in_stall));
    predict_item(it);
    if (typed) begin
      r.out_byte      = want;
      r.run_end       = 1'b1;
      r.hold_overflow = 1'b0;
      expected_bytes_q.insert(expected_bytes_q.size(), r);
    end else begin
      foreach (step_res[i]) expected_bytes_q.insert(expected_bytes_q.size(), step_res[i]);
    end
  endtask

  // drop valid, wait for every expected byte, then let held work finish
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_bytes_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic dfs_in_t mk_item(input logic op, input logic [7:0] b);
    dfs_in_t it;
    it.operation = op;
    it.data_byte = b;
    return it;
  endfunction

  task automatic plan_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    plan_row_t row;
    row.kind  = ROW_CFG;
    row.idx   = idx;
    row.val   = val;
    row.item  = '0;
    row.typed = 1'b0;
    row.want  = '0;
    plan_q.insert(plan_q.size(), row);
  endtask

  task automatic plan_item(input logic op, input logic [7:0] b, input bit typed,
                           input logic [7:0] want);
    plan_row_t row;
    row.kind  = ROW_ITEM;
    row.idx   = '0;
    row.val   = '0;
    row.item  = mk_item(op, b);
    row.typed = typed;
    row.want  = want;
    plan_q.insert(plan_q.size(), row);
  endtask

  function automatic logic [CFG_W-1:0] rand_range();
    logic [15:0] lo;
    logic [15:0] hi;
    lo = 16'($urandom_range(0, 5));
    hi = 16'($urandom_range(0, 6));
    if ($urandom_range(0, 7) == 0) lo = 16'($urandom_range(0, 65535));
    if ($urandom_range(0, 7) == 0) hi = 16'($urandom_range(0, 65535));
    return mk_range($urandom_range(0, 3) != 0, $urandom_range(0, 3) == 0, lo, hi);
  endfunction

  task automatic rand_setup(input int ph);
    logic [3:0] m;
    logic [7:0] s;
    logic [8:0] g;
    m = 4'($urandom_range(0, 15));
    m[MODE_FIELD] = $urandom_range(0, 3) != 0;
    case ($urandom_range(0, 7))
      0:       s = CH_TAB;
      1:       s = 8'h2C;
      2:       s = 8'h3A;
      3:       s = 8'h00;
      4:       s = 8'hFF;
      5:       s = TERM_NL;
      default: s = 8'($urandom_range(0, 255));
    endcase
    g = 9'($urandom_range(0, 511));
    // pin the register extremes in a few phases
    if (ph == 1) begin
      m = 4'hF;
      s = 8'hFF;
      g = 9'h1FF;
    end else if (ph == 2) begin
      // byte mode with complement, so most bytes come out while the receiver holds off
      m = 4'h2;
    end else if (ph == 3) begin
      m = 4'h0;
      s = 8'h00;
      g = 9'h000;
    end else if (ph == 4) begin
      m = 4'h1;
      s = 8'h00;
      g = 9'h000;
    end
    write_reg(REG_RANGE_A, rand_range());
    write_reg(REG_RANGE_B, rand_range());
    write_reg(REG_RANGE_C, rand_range());
    write_reg(REG_RANGE_D, rand_range());
    write_reg(REG_MODE, {{(CFG_W-4){1'b0}}, m});
    write_reg(REG_SPLIT, {{(CFG_W-8){1'b0}}, s});
    write_reg(REG_JOIN, {{(CFG_W-9){1'b0}}, g});
  endtask

  // mostly letters, split bytes and terminators so records get past the first field
  function automatic dfs_in_t rand_item();
    int         pick;
    logic [7:0] term;
    term = mode_r[MODE_NUL] ? TERM_NUL : TERM_NL;
    pick = $urandom_range(0, 99);
    if (pick < 50)      return mk_item(OP_DATA, 8'h61 + 8'($urandom_range(0, 3)));
    else if (pick < 75) return mk_item(OP_DATA, split_r);
    else if (pick < 87) return mk_item(OP_DATA, term);
    else if (pick < 90) return mk_item(OP_END, 8'($urandom_range(0, 255)));
    else                return mk_item(OP_DATA, 8'($urandom_range(0, 255)));
  endfunction

  // ---------------- receiver and checker ----------------

  initial begin : receiver
    int n;
    out_stall <= 1'b0;
    forever begin
      if (long_hold) begin
        n = LONG_HOLD_CYC;
        long_hold = 1'b0;
      end else begin
        n = out_idle_on ? $urandom_range(0, 15) : 0;
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    $display("%0t: mismatch on %s: got %h, want %h", $time, what, got, want);
    err_cnt++;
  endtask

  always @(posedge clk) begin : out_check
    dfs_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_bytes_q.size() == 0) begin
        report_mismatch("item with nothing expected", out_data.out_byte, 8'h00);
      end else begin
        want = expected_bytes_q.pop_front();
        if (out_data.out_byte !== want.out_byte)
          report_mismatch("out_byte", out_data.out_byte, want.out_byte);
        if (out_data.run_end !== want.run_end)
          report_mismatch("run_end", {7'd0, out_data.run_end}, {7'd0, want.run_end});
        if (out_data.hold_overflow !== want.hold_overflow)
          report_mismatch("hold_overflow", {7'd0, out_data.hold_overflow},
                          {7'd0, want.hold_overflow});
      end
    end
  end

  // ---------------- sequence ----------------

  initial begin : main_seq
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    in_idle_on  = 1'b1;
    out_idle_on = 1'b1;
    long_hold   = 1'b0;
    for (int k = 0; k < 4; k++) sel_range[k] = '0;
    mode_r      = 4'h0;
    split_r     = SPLIT_RESET;
    out_delim_r = JOIN_RESET;
    clear_record();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // defaults after reset: byte mode, nothing selected
    plan_item(OP_DATA, 8'h61, 1'b0, 8'h00);
    plan_item(OP_DATA, TERM_NL, 1'b1, TERM_NL);
    plan_item(OP_END, 8'h00, 1'b0, 8'h00);
    plan_item(OP_DATA, TERM_NL, 1'b1, TERM_NL);
    plan_cfg(REG_RANGE_A, mk_range(1'b1, 1'b0, 16'd0, 16'd0));
    plan_cfg(REG_RANGE_C, mk_range(1'b0, 1'b1, 16'd0, 16'hFFFF));
    plan_cfg(REG_RANGE_D, {CFG_W{1'b1}});
    plan_item(OP_DATA, 8'hFF, 1'b1, 8'hFF);
    plan_item(OP_DATA, 8'h00, 1'b0, 8'h00);
    plan_item(OP_END, 8'hFF, 1'b1, TERM_NL);
    // field mode, start above end, open-ended range
    plan_cfg(REG_MODE, 34'h1);
    plan_cfg(REG_RANGE_A, mk_range(1'b1, 1'b0, 16'd1, 16'd0));
    plan_cfg(REG_RANGE_B, mk_range(1'b1, 1'b1, 16'd1, 16'd0));
    plan_item(OP_DATA, 8'h78, 1'b0, 8'h00);
    plan_item(OP_DATA, CH_TAB, 1'b0, 8'h00);
    plan_item(OP_DATA, 8'h79, 1'b0, 8'h00);
    plan_item(OP_DATA, CH_TAB, 1'b0, 8'h00);
    plan_item(OP_DATA, 8'h7A, 1'b0, 8'h00);
    plan_item(OP_DATA, TERM_NL, 1'b0, 8'h00);
    plan_item(OP_DATA, 8'h71, 1'b0, 8'h00);
    plan_item(OP_DATA, TERM_NL, 1'b0, 8'h00);
    plan_item(OP_DATA, TERM_NL, 1'b1, TERM_NL);
    // NUL records, split equal to terminator, only delimited, no output delimiter
    plan_cfg(REG_SPLIT, 34'h0);
    plan_cfg(REG_MODE, 34'h1 | 34'h4 | 34'h8);
    plan_cfg(REG_JOIN, 34'h0FF);
    plan_item(OP_DATA, 8'h61, 1'b0, 8'h00);
    plan_item(OP_DATA, TERM_NUL, 1'b0, 8'h00);
    plan_item(OP_DATA, TERM_NL, 1'b0, 8'h00);
    plan_item(OP_END, 8'h00, 1'b0, 8'h00);
    // every mode bit set, complement keeps only the first field
    plan_cfg(REG_SPLIT, 34'hFF);
    plan_cfg(REG_MODE, 34'hF);
    plan_cfg(REG_JOIN, 34'h1FF);
    plan_item(OP_DATA, 8'h70, 1'b0, 8'h00);
    plan_item(OP_DATA, 8'hFF, 1'b0, 8'h00);
    plan_item(OP_DATA, 8'h72, 1'b0, 8'h00);
    plan_item(OP_DATA, 8'hFF, 1'b0, 8'h00);
    plan_item(OP_DATA, TERM_NUL, 1'b0, 8'h00);

    foreach (plan_q[i]) begin
      if (plan_q[i].kind == ROW_CFG) begin
        settle();
        write_reg(plan_q[i].idx, plan_q[i].val);
      end else begin
        send_item(plan_q[i].item, plan_q[i].typed, plan_q[i].want);
      end
    end

    // first field longer than the hold store, delimited then undelimited
    settle();
    write_reg(REG_MODE, 34'h1);
    write_reg(REG_SPLIT, {26'd0, CH_TAB});
    write_reg(REG_JOIN, {25'd0, JOIN_RESET});
    write_reg(REG_RANGE_A, mk_range(1'b1, 1'b0, 16'd0, 16'd1));
    write_reg(REG_RANGE_B, '0);
    for (int i = 0; i < OVF_LEN; i++)
      send_item(mk_item(OP_DATA, 8'h61 + 8'(i % 26)), 1'b0, 8'h00);
    send_item(mk_item(OP_DATA, CH_TAB), 1'b0, 8'h00);
    send_item(mk_item(OP_DATA, 8'h6B), 1'b0, 8'h00);
    send_item(mk_item(OP_DATA, CH_TAB), 1'b0, 8'h00);
    send_item(mk_item(OP_DATA, 8'h6D), 1'b0, 8'h00);
    send_item(mk_item(OP_DATA, TERM_NL), 1'b0, 8'h00);
    for (int i = 0; i < OVF_LEN; i++)
      send_item(mk_item(OP_DATA, 8'h41 + 8'(i % 26)), 1'b0, 8'h00);
    send_item(mk_item(OP_DATA, TERM_NL), 1'b0, 8'h00);

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      settle();
      rand_setup(ph);
      in_idle_on  = (ph % 3) != 0;
      out_idle_on = (ph % 4) != 1;
      // hold the receiver off while the sender streams, so the core backs up
      if (ph == 2) begin
        in_idle_on = 1'b0;
        long_hold  = 1'b1;
      end
      for (int n = 0; n < ITEMS_PER_PHASE; n++) send_item(rand_item(), 1'b0, 8'h00);
    end

    settle();
    if (err_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
